### rtl/rgbyuv_pkg.sv
`default_nettype none

package rgbyuv_pkg;

   // configuration register map
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 13;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam int FRAME_WIDTH_BITS  = 11;
   localparam int FRAME_HEIGHT_BITS = 13;
   localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [FRAME_HEIGHT_BITS-1:0] MAX_HEIGHT         = 13'd4096;

   localparam int MAX_WIDTH_DEFAULT = 1024;

   // fixed field widths
   localparam int PIXEL_BITS  = 8;
   localparam int COLUMN_BITS = 10;
   localparam int ROW_BITS    = 12;

   // queue depths
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // fixed point color transform
   localparam int PROD_BITS    = 25;
   localparam int LUMA_SHIFT   = 15;
   localparam int CHROMA_SHIFT = 17;
   localparam logic [PIXEL_BITS-1:0] CHROMA_OFFSET = 8'd32;

   typedef logic signed [PROD_BITS-1:0] prod_type;

   localparam prod_type Y_R_COEF  = prod_type'(9796);
   localparam prod_type Y_G_COEF  = prod_type'(19235);
   localparam prod_type Y_B_COEF  = prod_type'(3736);
   localparam prod_type CB_R_COEF = prod_type'(-4784);
   localparam prod_type CB_G_COEF = prod_type'(-9437);
   localparam prod_type CB_B_COEF = prod_type'(14221);
   localparam prod_type CR_R_COEF = prod_type'(20218);
   localparam prod_type CR_G_COEF = prod_type'(-16941);
   localparam prod_type CR_B_COEF = prod_type'(-3277);

   // position class of a pixel, decided by the front end
   typedef struct packed {
      logic odd_col;
      logic odd_row;
      logic frame_end;
   } cls_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]  luma;
      logic                   chroma_valid;
      logic [PIXEL_BITS-1:0]  cb;
      logic [PIXEL_BITS-1:0]  cr;
      logic [COLUMN_BITS-1:0] pixel_column;
      logic [ROW_BITS-1:0]    pixel_row;
      logic                   frame_end;
   } rsp_type;

   function automatic prod_type widen(input logic [PIXEL_BITS-1:0] v);
      widen = prod_type'({1'b0, v});
   endfunction

endpackage

`default_nettype wire

### rtl/rgbyuv_ram.sv
`default_nettype none

module rgbyuv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/rgbyuv_fifo.sv
`default_nettype none

module rgbyuv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           din,
   output logic                            full,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           dout,
   output logic                            empty,
   output logic      [$clog2(DEPTH+1)-1:0] level
);

   localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LvlBits = $clog2(DEPTH+1);
   localparam logic [PtrBits-1:0] LastPtr  = PtrBits'(DEPTH - 1);
   localparam logic [LvlBits-1:0] FullLvl  = LvlBits'(DEPTH);

   logic [WIDTH-1:0]   storage_ff [DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LvlBits-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == FullLvl);
   assign empty   = (count_ff == '0);
   assign level   = count_ff;
   assign dout    = storage_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         storage_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

### rtl/rgbyuv_front.sv
`default_nettype none

module rgbyuv_front
   import rgbyuv_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  wire logic                          push,
   input  wire logic                          mid_full,
   output logic                              item_valid,
   output logic      [$clog2(MAX_WIDTH)-1:0] item_col,
   output logic      [ROW_BITS-1:0]          item_row,
   output cls_type                           item_cls
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int AwBits = ((CW + 1) > FRAME_WIDTH_BITS) ? (CW + 1) : FRAME_WIDTH_BITS;
   localparam logic [AwBits-1:0] MaxWEven = AwBits'(MAX_WIDTH - (MAX_WIDTH % 2));
   localparam logic [AwBits-1:0] MinW     = AwBits'(2);
   localparam logic [FRAME_HEIGHT_BITS-1:0] MinH = FRAME_HEIGHT_BITS'(2);

   logic [FRAME_WIDTH_BITS-1:0]  width_ff;
   logic [FRAME_HEIGHT_BITS-1:0] height_ff;
   logic [CW-1:0]                col_ff, col_in;
   logic [ROW_BITS-1:0]          row_ff, row_in;

   logic [AwBits-1:0]            w_even, active_w, col_next;
   logic [FRAME_HEIGHT_BITS-1:0] h_even, active_h, row_next;
   logic                         last_col, last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[FRAME_WIDTH_BITS-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata[FRAME_HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // active frame size: even, clamped to what the line store and row count hold
   always_comb begin
      w_even = AwBits'({width_ff[FRAME_WIDTH_BITS-1:1], 1'b0});
      if (w_even < MinW) begin
         active_w = MinW;
      end else if (w_even > MaxWEven) begin
         active_w = MaxWEven;
      end else begin
         active_w = w_even;
      end
      h_even = {height_ff[FRAME_HEIGHT_BITS-1:1], 1'b0};
      if (h_even < MinH) begin
         active_h = MinH;
      end else if (h_even > MAX_HEIGHT) begin
         active_h = MAX_HEIGHT;
      end else begin
         active_h = h_even;
      end
   end

   assign col_next   = AwBits'(col_ff) + AwBits'(1);
   assign row_next   = FRAME_HEIGHT_BITS'(row_ff) + FRAME_HEIGHT_BITS'(1);
   assign last_col   = (col_next >= active_w);
   assign last_row   = (row_next >= active_h);
   assign item_valid = push && !mid_full;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (item_valid) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[ROW_BITS-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign item_col            = col_ff;
   assign item_row            = row_ff;
   assign item_cls.odd_col    = col_ff[0];
   assign item_cls.odd_row    = row_ff[0];
   assign item_cls.frame_end  = last_col && last_row;

endmodule

`default_nettype wire

### rtl/rgbyuv_back.sv
`default_nettype none

module rgbyuv_back
   import rgbyuv_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            mid_empty,
   input  wire logic [PIXEL_BITS-1:0]           red,
   input  wire logic [PIXEL_BITS-1:0]           green,
   input  wire logic [PIXEL_BITS-1:0]           blue,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]    col,
   input  wire logic [ROW_BITS-1:0]             row,
   input  wire cls_type                         cls,
   output logic                                 mid_pop,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0]  out_level,
   output logic                                 out_push,
   output rsp_type                              out_item
);

   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int LineDepth = MAX_WIDTH / 2;
   localparam int AddrBits  = $clog2(LineDepth);
   localparam int LvlBits   = $clog2(OUT_DEPTH+1);
   localparam logic [LvlBits:0] OutLimit = (LvlBits+1)'(OUT_DEPTH);

   prod_type             r_w, g_w, b_w;
   logic [CW-1:0]        slot_full;
   logic [AddrBits-1:0]  slot;

   logic                 s1_valid_ff;
   prod_type             s1_y_ff, s1_cb_ff, s1_cr_ff;
   logic [CW-1:0]        s1_col_ff;
   logic [ROW_BITS-1:0]  s1_row_ff;
   cls_type              s1_cls_ff;
   logic [AddrBits-1:0]  s1_slot_ff;

   logic [PIXEL_BITS-1:0] pair_cb_ff, pair_cb_in;
   logic [PIXEL_BITS-1:0] pair_cr_ff, pair_cr_in;
   logic [PIXEL_BITS-1:0] cb_term, cr_term;
   logic [2*PIXEL_BITS-1:0] held;
   logic                  line_wr, block_done;
   logic [CW+COLUMN_BITS-1:0] col_ext;

   // only take an item when the result queue is sure to have room for it
   assign mid_pop = !mid_empty &&
                    (({1'b0, out_level} + (LvlBits+1)'(s1_valid_ff)) < OutLimit);

   assign r_w       = widen(red);
   assign g_w       = widen(green);
   assign b_w       = widen(blue);
   assign slot_full = col >> 1;
   assign slot      = slot_full[AddrBits-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         s1_y_ff    <= Y_R_COEF * r_w + Y_G_COEF * g_w + Y_B_COEF * b_w;
         s1_cb_ff   <= CB_R_COEF * r_w + CB_G_COEF * g_w + CB_B_COEF * b_w;
         s1_cr_ff   <= CR_R_COEF * r_w + CR_G_COEF * g_w + CR_B_COEF * b_w;
         s1_col_ff  <= col;
         s1_row_ff  <= row;
         s1_cls_ff  <= cls;
         s1_slot_ff <= slot;
      end
   end

   // floor shift: the top bits of the two's complement sum, then the offset
   assign cb_term = s1_cb_ff[PROD_BITS-1:CHROMA_SHIFT] + CHROMA_OFFSET;
   assign cr_term = s1_cr_ff[PROD_BITS-1:CHROMA_SHIFT] + CHROMA_OFFSET;

   always_comb begin
      if (s1_cls_ff.odd_col) begin
         pair_cb_in = pair_cb_ff + cb_term;
         pair_cr_in = pair_cr_ff + cr_term;
      end else begin
         pair_cb_in = cb_term;
         pair_cr_in = cr_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_cb_ff <= '0;
         pair_cr_ff <= '0;
      end else if (s1_valid_ff) begin
         pair_cb_ff <= pair_cb_in;
         pair_cr_ff <= pair_cr_in;
      end
   end

   assign line_wr    = s1_valid_ff && s1_cls_ff.odd_col && !s1_cls_ff.odd_row;
   assign block_done = s1_cls_ff.odd_col && s1_cls_ff.odd_row;

   rgbyuv_ram #(
      .WIDTH (2*PIXEL_BITS),
      .DEPTH (LineDepth)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s1_slot_ff),
      .wr_data ({pair_cr_in, pair_cb_in}),
      .rd_en   (mid_pop),
      .rd_addr (slot),
      .rd_data (held)
   );

   assign col_ext = {{COLUMN_BITS{1'b0}}, s1_col_ff};

   always_comb begin
      out_item.luma         = s1_y_ff[LUMA_SHIFT+PIXEL_BITS-1:LUMA_SHIFT];
      out_item.chroma_valid = block_done;
      out_item.cb           = block_done ? pair_cb_in + held[PIXEL_BITS-1:0] : '0;
      out_item.cr           = block_done ? pair_cr_in + held[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
      out_item.pixel_column = col_ext[COLUMN_BITS-1:0];
      out_item.pixel_row    = s1_row_ff;
      out_item.frame_end    = s1_cls_ff.frame_end;
   end

   assign out_push = s1_valid_ff;

endmodule

`default_nettype wire

### rtl/rgb_to_yuv420_converter_core.sv
// Path: an accepted pixel passes the pixel queue, product registers, result queue.
// Throughput: one pixel per cycle while the receiver pops; the multiply and line
// store read path and the small result queue each take one transaction per cycle.
// Reset: synchronous, active high; clears counters, queues and chroma pair sums
// and loads frame width 640, height 480. The chroma line store is not cleared.
`default_nettype none

module rgb_to_yuv420_converter_core
   import rgbyuv_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [PIXEL_BITS-1:0]       req_red,
   input  wire logic [PIXEL_BITS-1:0]       req_green,
   input  wire logic [PIXEL_BITS-1:0]       req_blue,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic      [PIXEL_BITS-1:0]       rsp_luma,
   output logic                             rsp_chroma_valid,
   output logic      [PIXEL_BITS-1:0]       rsp_cb,
   output logic      [PIXEL_BITS-1:0]       rsp_cr,
   output logic      [COLUMN_BITS-1:0]      rsp_pixel_column,
   output logic      [ROW_BITS-1:0]         rsp_pixel_row,
   output logic                             rsp_frame_end
);

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int MidBits = 3*PIXEL_BITS + CW + ROW_BITS + $bits(cls_type);
   localparam int RspBits = $bits(rsp_type);

   logic                          item_valid;
   logic [CW-1:0]                 item_col;
   logic [ROW_BITS-1:0]           item_row;
   cls_type                       item_cls;

   logic [MidBits-1:0]            mid_din, mid_dout;
   logic                          mid_full, mid_empty, mid_pop;
   logic [$clog2(MID_DEPTH+1)-1:0] mid_level;

   logic [PIXEL_BITS-1:0]         mid_red, mid_green, mid_blue;
   logic [CW-1:0]                 mid_col;
   logic [ROW_BITS-1:0]           mid_row;
   cls_type                       mid_cls;

   logic                          out_push, out_full;
   rsp_type                       out_item, rsp_item;
   logic [RspBits-1:0]            rsp_bits;
   logic [$clog2(OUT_DEPTH+1)-1:0] out_level;

   rgbyuv_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (req_push),
      .mid_full   (mid_full),
      .item_valid (item_valid),
      .item_col   (item_col),
      .item_row   (item_row),
      .item_cls   (item_cls)
   );

   assign req_full = mid_full;
   assign mid_din  = {req_red, req_green, req_blue, item_col, item_row, item_cls};

   rgbyuv_fifo #(
      .WIDTH (MidBits),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (item_valid),
      .din   (mid_din),
      .full  (mid_full),
      .pop   (mid_pop),
      .dout  (mid_dout),
      .empty (mid_empty),
      .level (mid_level)
   );

   assign {mid_red, mid_green, mid_blue, mid_col, mid_row, mid_cls} = mid_dout;

   rgbyuv_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .red       (mid_red),
      .green     (mid_green),
      .blue      (mid_blue),
      .col       (mid_col),
      .row       (mid_row),
      .cls       (mid_cls),
      .mid_pop   (mid_pop),
      .out_level (out_level),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   rgbyuv_fifo #(
      .WIDTH (RspBits),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_item),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (rsp_bits),
      .empty (rsp_empty),
      .level (out_level)
   );

   assign rsp_item         = rsp_type'(rsp_bits);
   assign rsp_luma         = rsp_item.luma;
   assign rsp_chroma_valid = rsp_item.chroma_valid;
   assign rsp_cb           = rsp_item.cb;
   assign rsp_cr           = rsp_item.cr;
   assign rsp_pixel_column = rsp_item.pixel_column;
   assign rsp_pixel_row    = rsp_item.pixel_row;
   assign rsp_frame_end    = rsp_item.frame_end;

   // the credit check must keep the result queue from ever dropping a transaction
   a_no_out_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result queue overflow");

   a_mid_bound: assert property (@(posedge clock) disable iff (reset)
      mid_level <= MID_DEPTH[$clog2(MID_DEPTH+1)-1:0])
      else $error("pixel queue level out of range");

   a_chroma_position: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_chroma_valid) |-> (rsp_pixel_column[0] && rsp_pixel_row[0]))
      else $error("chroma on a pixel that does not close a block");

   a_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_chroma_valid) |-> (rsp_cb == '0 && rsp_cr == '0))
      else $error("chroma fields set without a finished block");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not cleared by reset");

endmodule

`default_nettype wire

### tb/yuv420_stream_checker.sv
module yuv420_stream_checker
   import rgbyuv_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]     csr_wdata,
   input  wire logic                         req_push,
   input  wire logic                         req_full,
   input  wire logic [PIXEL_BITS-1:0]        req_red,
   input  wire logic [PIXEL_BITS-1:0]        req_green,
   input  wire logic [PIXEL_BITS-1:0]        req_blue,
   input  wire logic                         rsp_empty,
   input  wire logic                         rsp_pop,
   input  wire logic [PIXEL_BITS-1:0]        rsp_luma,
   input  wire logic                         rsp_chroma_valid,
   input  wire logic [PIXEL_BITS-1:0]        rsp_cb,
   input  wire logic [PIXEL_BITS-1:0]        rsp_cr,
   input  wire logic [COLUMN_BITS-1:0]       rsp_pixel_column,
   input  wire logic [ROW_BITS-1:0]          rsp_pixel_row,
   input  wire logic                         rsp_frame_end,
   output int                                fail_count,
   output int                                pending_count
);

   localparam int LINE_SLOTS = MAX_WIDTH_DEFAULT / 2;

   logic [FRAME_WIDTH_BITS-1:0]  width_reg;
   logic [FRAME_HEIGHT_BITS-1:0] height_reg;
   int unsigned                  col_pos;
   int unsigned                  row_pos;
   logic [PIXEL_BITS-1:0]        pair_cb;
   logic [PIXEL_BITS-1:0]        pair_cr;
   logic [15:0]                  chroma_line [LINE_SLOTS];
   rsp_type                      expected_pixels [$];

   // floor division by 2^17 via arithmetic shift, then offset, kept modulo 256
   function automatic logic [PIXEL_BITS-1:0] chroma_term(input int mix);
      return 8'((mix >>> CHROMA_SHIFT) + 32);
   endfunction

   function automatic rsp_type convert_pixel(input logic [PIXEL_BITS-1:0] r, g, b);
      rsp_type               px;
      int                    ri, gi, bi;
      int unsigned           w_act, h_act, slot;
      logic [PIXEL_BITS-1:0] cb_term, cr_term;
      logic [15:0]           held;
      logic                  row_done;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      px = '0;
      px.luma = 8'((9796 * ri + 19235 * gi + 3736 * bi) >> LUMA_SHIFT);
      cb_term = chroma_term(-4784 * ri - 9437 * gi + 14221 * bi);
      cr_term = chroma_term(20218 * ri - 16941 * gi - 3277 * bi);
      slot = col_pos >> 1;
      if (!col_pos[0]) begin
         pair_cb = cb_term;
         pair_cr = cr_term;
      end else begin
         pair_cb = pair_cb + cb_term;
         pair_cr = pair_cr + cr_term;
         if (!row_pos[0]) begin
            chroma_line[slot] = {pair_cr, pair_cb};
         end else begin
            held = chroma_line[slot];
            px.chroma_valid = 1'b1;
            px.cb = pair_cb + held[7:0];
            px.cr = pair_cr + held[15:8];
         end
      end
      w_act = {width_reg[FRAME_WIDTH_BITS-1:1], 1'b0};
      if (w_act < 2) w_act = 2;
      if (w_act > MAX_WIDTH_DEFAULT) w_act = MAX_WIDTH_DEFAULT;
      h_act = {height_reg[FRAME_HEIGHT_BITS-1:1], 1'b0};
      if (h_act < 2) h_act = 2;
      if (h_act > MAX_HEIGHT) h_act = MAX_HEIGHT;
      row_done = (col_pos + 1 >= w_act);
      px.pixel_column = col_pos[COLUMN_BITS-1:0];
      px.pixel_row = row_pos[ROW_BITS-1:0];
      px.frame_end = row_done && (row_pos + 1 >= h_act);
      // a counter past a shrunk size also ends its row or frame here
      if (row_done) begin
         col_pos = 0;
         row_pos = px.frame_end ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return px;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         width_reg = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         col_pos = 0;
         row_pos = 0;
         pair_cb = '0;
         pair_cr = '0;
         expected_pixels.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_reg = csr_wdata[FRAME_WIDTH_BITS-1:0];
               CSR_FRAME_HEIGHT: height_reg = csr_wdata[FRAME_HEIGHT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            expected_pixels.push_back(convert_pixel(req_red, req_green, req_blue));
         end
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_luma, rsp_chroma_valid, rsp_cb, rsp_cr, rsp_pixel_column,
                   rsp_pixel_row, rsp_frame_end};
            if (expected_pixels.size() == 0) begin
               $error("pixel result popped with no transaction waiting");
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("luma", want.luma, got.luma);
               check_field("chroma_valid", want.chroma_valid, got.chroma_valid);
               check_field("cb", want.cb, got.cb);
               check_field("cr", want.cr, got.cr);
               check_field("pixel_column", want.pixel_column, got.pixel_column);
               check_field("pixel_row", want.pixel_row, got.pixel_row);
               check_field("frame_end", want.frame_end, got.frame_end);
            end
         end
      end
      pending_count <= expected_pixels.size();
   end

endmodule

### tb/tb_rgb_to_yuv420_converter_core.sv
module tb_rgb_to_yuv420_converter_core;
   import rgbyuv_pkg::*;

   localparam int QUIET_LIMIT     = 2000;
   localparam int PIPE_CYCLES     = 2;
   localparam int PIXELS_PER_MODE = 160;
   localparam int HOLD_CYCLES     = 80;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   logic                      req_push;
   logic                      req_full;
   logic [PIXEL_BITS-1:0]     req_red;
   logic [PIXEL_BITS-1:0]     req_green;
   logic [PIXEL_BITS-1:0]     req_blue;
   logic                      rsp_empty;
   logic                      rsp_pop;
   logic [PIXEL_BITS-1:0]     rsp_luma;
   logic                      rsp_chroma_valid;
   logic [PIXEL_BITS-1:0]     rsp_cb;
   logic [PIXEL_BITS-1:0]     rsp_cr;
   logic [COLUMN_BITS-1:0]    rsp_pixel_column;
   logic [ROW_BITS-1:0]       rsp_pixel_row;
   logic                      rsp_frame_end;

   int fail_count;
   int pending_count;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int hold_len = 0;
   int n_sent = 0;

   rgb_to_yuv420_converter_core uut (.*);

   yuv420_stream_checker watch (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [PIXEL_BITS-1:0] pick_level();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic int frame_pixels(input int w, input int h);
      int wa, ha;
      wa = w & ~1;
      ha = h & ~1;
      if (wa < 2) wa = 2;
      if (wa > MAX_WIDTH_DEFAULT) wa = MAX_WIDTH_DEFAULT;
      if (ha < 2) ha = 2;
      if (ha > MAX_HEIGHT) ha = MAX_HEIGHT;
      return wa * ha;
   endfunction

   task automatic push_pixel(input logic [PIXEL_BITS-1:0] r, g, b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      n_sent++;
   endtask

   // step past the last push first so the count includes the last transaction
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 2) @(posedge clock);
   endtask

   task automatic set_frame(input logic [FRAME_WIDTH_BITS-1:0] w,
                            input logic [FRAME_HEIGHT_BITS-1:0] h);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= CSR_DATA_BITS'(w);
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random(input int count);
      repeat (count) push_pixel(pick_level(), pick_level(), pick_level());
   endtask

   task automatic run_frame(input int w, input int h);
      set_frame(FRAME_WIDTH_BITS'(w), FRAME_HEIGHT_BITS'(h));
      send_random(frame_pixels(w, h));
      drain();
   endtask

   initial begin : receiver
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_pop <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int mode;
      int quota;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      req_push <= 1'b0;
      req_red <= '0;
      req_green <= '0;
      req_blue <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sizes below range clamp to 2x2; two frames of corner colors
      set_frame(11'd1, 13'd0);
      push_pixel(8'h00, 8'h00, 8'h00);
      push_pixel(8'hff, 8'hff, 8'hff);
      push_pixel(8'hff, 8'h00, 8'h00);
      push_pixel(8'h00, 8'hff, 8'h00);
      push_pixel(8'h00, 8'h00, 8'hff);
      push_pixel(8'h00, 8'hff, 8'hff);
      push_pixel(8'hff, 8'h00, 8'hff);
      push_pixel(8'hff, 8'hff, 8'h00);
      drain();

      // width drops below the column counter: row 0 ends on column 4
      set_frame(11'd6, 13'd2);
      send_random(4);
      drain();
      set_frame(11'd2, 13'd2);
      send_random(3);
      drain();

      // height drops below the row counter: frame ends on row 3
      set_frame(11'd2, 13'd6);
      send_random(6);
      drain();
      set_frame(11'd2, 13'd2);
      send_random(2);
      drain();

      // receiver holds off while pixels keep coming, so the block backs up
      hold_len = HOLD_CYCLES;
      run_frame(16, 4);

      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 0;
               pop_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 60;
               pop_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               pop_stall_pct = 60;
            end
            default: begin
               send_idle_pct = 13;
               pop_stall_pct = 13;
            end
         endcase
         quota = n_sent + PIXELS_PER_MODE;
         while (n_sent < quota) run_frame($urandom_range(0, 26), $urandom_range(0, 9));
      end

      // all-ones register values: part of a wide row, then a small size ends the frame
      set_frame(11'h7ff, 13'h1fff);
      send_random(40);
      drain();
      set_frame(11'd2, 13'd2);
      send_random(3);
      drain();

      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
rtl/rgbyuv_pkg.sv
rtl/rgbyuv_ram.sv
rtl/rgbyuv_fifo.sv
rtl/rgbyuv_front.sv
rtl/rgbyuv_back.sv
rtl/rgb_to_yuv420_converter_core.sv
tb/yuv420_stream_checker.sv
tb/tb_rgb_to_yuv420_converter_core.sv
